[hdl/awfd_pkg.sv]
// ----------------------------------------------------------------------------
// awfd_pkg
// Shared types, constants and the Laplacian coefficient table for the
// acoustic wave finite difference step.
// ----------------------------------------------------------------------------
package awfd_pkg;

    localparam int MAX_H    = 1024;
    localparam int MIN_H    = 10;
    localparam int H_W      = 11;
    localparam int ROW_W    = $clog2(MAX_H);
    localparam int HALF     = 4;
    localparam int NCOLS    = 2 * HALF;
    localparam int SLOT_W   = $clog2(NCOLS);
    localparam int CNT_W    = $clog2(NCOLS) + 1;
    localparam int ADDR_W   = SLOT_W + ROW_W;
    localparam int P_W      = 32;
    localparam int G_W      = 16;
    localparam int COEF_W   = 28;
    localparam int PROD_W   = COEF_W + P_W;
    localparam int ACC_W    = 64;
    localparam int LAP_W    = 40;
    localparam int DIFF_W   = 41;
    localparam int M1_W     = DIFF_W + G_W + 1;
    localparam int M2_W     = P_W + G_W + 2;
    localparam int NUM_W    = 60;
    localparam int DVD_W    = 60;
    localparam int DEN_W    = G_W + 1;
    localparam int DCNT_W   = $clog2(DVD_W);
    localparam int TERM_W   = 5;
    localparam int LAP_SHIFT = 24;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);

    // term index of the lead point, which comes from the item, not memory
    localparam logic [TERM_W-1:0] TERM_LEAD = 5'd16;

    localparam logic signed [COEF_W-1:0] C0 = -28'sd95536850;
    localparam logic signed [COEF_W-1:0] C1 = 28'sd26843546;
    localparam logic signed [COEF_W-1:0] C2 = -28'sd3355443;
    localparam logic signed [COEF_W-1:0] C3 = 28'sd426088;
    localparam logic signed [COEF_W-1:0] C4 = -28'sd29959;

    typedef struct packed {
        logic signed [P_W-1:0] lead_pressure;
        logic signed [P_W-1:0] center_prev_pressure;
        logic [G_W-1:0]        velocity_coef;
        logic [G_W-1:0]        damping;
        logic signed [P_W-1:0] source_term;
        logic                  frame_start;
    } t_in_item;

    typedef struct packed {
        logic signed [P_W-1:0] new_pressure;
        logic                  stencil_applied;
    } t_out_item;

    typedef struct packed {
        logic signed [P_W-1:0] lead;
        logic signed [P_W-1:0] prev;
        logic [G_W-1:0]        vel;
        logic [G_W-1:0]        damp;
        logic signed [P_W-1:0] src;
        logic [ROW_W-1:0]      row;
        logic [SLOT_W-1:0]     slot;
        logic                  emit;
        logic                  stencil;
    } t_job;

    typedef enum logic [3:0] {
        B_IDLE,
        B_READ,
        B_DRAIN,
        B_LAP,
        B_DIFF,
        B_MUL,
        B_NUM,
        B_ABS,
        B_DIV,
        B_SAT,
        B_FIN
    } t_bstate;

    // terms: center, four up, four down, three right, three left, far left, lead
    function automatic logic signed [COEF_W-1:0] term_coef(input logic [TERM_W-1:0] idx);
        logic signed [COEF_W-1:0] c;
        case (idx) inside
            5'd0:                     c = C0;
            5'd1, 5'd5, 5'd9, 5'd12:  c = C1;
            5'd2, 5'd6, 5'd10, 5'd13: c = C2;
            5'd3, 5'd7, 5'd11, 5'd14: c = C3;
            default:                  c = C4;
        endcase
        return c;
    endfunction

endpackage

[hdl/awfd_front.sv]
// ----------------------------------------------------------------------------
// awfd_front
// Accepts grid points, tracks row, column count and buffer slot, and
// classifies each point before handing it to the queue.
// ----------------------------------------------------------------------------
module awfd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [awfd_pkg::H_W-1:0]      i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  awfd_pkg::t_in_item            i_in_item,
    input  logic                          i_full,
    output logic                          o_push,
    output awfd_pkg::t_job                o_job
);

    localparam int H_W    = awfd_pkg::H_W;
    localparam int ROW_W  = awfd_pkg::ROW_W;
    localparam int SLOT_W = awfd_pkg::SLOT_W;
    localparam int CNT_W  = awfd_pkg::CNT_W;

    logic [H_W-1:0]    r_height;
    logic [ROW_W-1:0]  r_row;
    logic [CNT_W-1:0]  r_cols;
    logic [SLOT_W-1:0] r_lead;

    logic [H_W-1:0]    h;
    logic [ROW_W-1:0]  rc0;
    logic [ROW_W-1:0]  row;
    logic [CNT_W-1:0]  cs0;
    logic [SLOT_W-1:0] ls0;
    logic              col_end;
    logic              stencil;

    always_comb begin
        if (r_height < H_W'(awfd_pkg::MIN_H)) begin
            h = H_W'(awfd_pkg::MIN_H);
        end else if (r_height > H_W'(awfd_pkg::MAX_H)) begin
            h = H_W'(awfd_pkg::MAX_H);
        end else begin
            h = r_height;
        end
        rc0 = i_in_item.frame_start ? '0 : r_row;
        cs0 = i_in_item.frame_start ? '0 : r_cols;
        ls0 = i_in_item.frame_start ? '0 : r_lead;
        // a height lowered mid-column ends the column early
        if ({1'b0, rc0} >= h) begin
            row = ROW_W'(h - H_W'(1));
        end else begin
            row = rc0;
        end
        col_end = ({1'b0, row} + H_W'(1)) >= h;
        stencil = (cs0 >= CNT_W'(awfd_pkg::NCOLS)) && (row >= ROW_W'(awfd_pkg::HALF))
                  && (({1'b0, row} + H_W'(awfd_pkg::HALF + 2)) <= h);
    end

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        o_job.lead    = i_in_item.lead_pressure;
        o_job.prev    = i_in_item.center_prev_pressure;
        o_job.vel     = i_in_item.velocity_coef;
        o_job.damp    = i_in_item.damping;
        o_job.src     = i_in_item.source_term;
        o_job.row     = row;
        o_job.slot    = ls0;
        o_job.emit    = cs0 >= CNT_W'(awfd_pkg::HALF);
        o_job.stencil = stencil;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= H_W'(awfd_pkg::MAX_H);
            r_row    <= '0;
            r_cols   <= '0;
            r_lead   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_height <= i_cfg_wr_data;
            end
            if (o_push) begin
                if (col_end) begin
                    r_row  <= '0;
                    r_cols <= (cs0 < CNT_W'(awfd_pkg::NCOLS)) ? cs0 + CNT_W'(1) : cs0;
                    r_lead <= ls0 + SLOT_W'(1);
                end else begin
                    r_row  <= row + ROW_W'(1);
                    r_cols <= cs0;
                    r_lead <= ls0;
                end
            end
        end
    end

    a_cols_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cols <= CNT_W'(awfd_pkg::NCOLS))
        else $error("column count past saturation");

endmodule

[hdl/awfd_queue.sv]
// ----------------------------------------------------------------------------
// awfd_queue
// Short queue of classified points between the front and the back.
// ----------------------------------------------------------------------------
module awfd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  awfd_pkg::t_job i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output awfd_pkg::t_job o_item
);

    localparam int QDEPTH = awfd_pkg::QDEPTH;
    localparam int QPTR_W = awfd_pkg::QPTR_W;

    awfd_pkg::t_job    r_slots [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = r_count == (QPTR_W+1)'(QDEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");

endmodule

[hdl/awfd_back.sv]
// ----------------------------------------------------------------------------
// awfd_back
// Carries out one point at a time: for stencil points gathers the stencil from
// the column memory, accumulates the Laplacian, forms the update and divides by
// the damping denominator; then stores the lead pressure and posts the result.
// ----------------------------------------------------------------------------
module awfd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  awfd_pkg::t_job       i_q_item,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output awfd_pkg::t_out_item  o_out_item
);

    localparam int ROW_W  = awfd_pkg::ROW_W;
    localparam int SLOT_W = awfd_pkg::SLOT_W;
    localparam int ADDR_W = awfd_pkg::ADDR_W;
    localparam int P_W    = awfd_pkg::P_W;
    localparam int G_W    = awfd_pkg::G_W;
    localparam int PROD_W = awfd_pkg::PROD_W;
    localparam int ACC_W  = awfd_pkg::ACC_W;
    localparam int LAP_W  = awfd_pkg::LAP_W;
    localparam int DIFF_W = awfd_pkg::DIFF_W;
    localparam int M1_W   = awfd_pkg::M1_W;
    localparam int M2_W   = awfd_pkg::M2_W;
    localparam int NUM_W  = awfd_pkg::NUM_W;
    localparam int DVD_W  = awfd_pkg::DVD_W;
    localparam int DEN_W  = awfd_pkg::DEN_W;
    localparam int DCNT_W = awfd_pkg::DCNT_W;
    localparam int TERM_W = awfd_pkg::TERM_W;
    localparam logic [ACC_W-1:0] LAP_RND = ACC_W'(1) << (awfd_pkg::LAP_SHIFT - 1);
    localparam logic [DVD_W-1:0] P_MAX = DVD_W'((64'd1 << (P_W - 1)) - 64'd1);
    localparam logic [DVD_W-1:0] P_MIN_MAG = DVD_W'(64'd1 << (P_W - 1));

    awfd_pkg::t_bstate r_state, n_state;

    logic [P_W-1:0]               r_mem [1 << ADDR_W];
    awfd_pkg::t_job               r_job;
    logic [TERM_W-1:0]            r_idx;
    logic [P_W-1:0]               r_rd_q;
    logic                         r_rd_v;
    logic [TERM_W-1:0]            r_rd_tag;
    logic signed [PROD_W-1:0]     r_prod;
    logic                         r_prod_v;
    logic signed [ACC_W-1:0]      r_acc;
    logic signed [P_W-1:0]        r_pc;
    logic signed [LAP_W-1:0]      r_lap;
    logic signed [DIFF_W-1:0]     r_diff;
    logic signed [M1_W-1:0]       r_m1;
    logic signed [M2_W-1:0]       r_m2;
    logic signed [NUM_W-1:0]      r_num;
    logic [DEN_W-1:0]             r_den;
    logic                         r_neg;
    logic [DVD_W-1:0]             r_dvd;
    logic [DEN_W-1:0]             r_rem;
    logic [DCNT_W-1:0]            r_cnt;
    logic signed [P_W-1:0]        r_res;
    logic                         r_applied;
    logic                         r_out_valid;
    awfd_pkg::t_out_item          r_out;

    logic                  out_free;
    logic                  rd_issue;
    logic                  mem_we;
    logic                  out_load;
    logic [SLOT_W-1:0]     cs;
    logic [SLOT_W-1:0]     rd_col;
    logic [ROW_W-1:0]      rd_row;
    logic [2:0]            k;
    logic signed [P_W-1:0] term;
    logic [ACC_W-1:0]      acc_mag;
    logic [ACC_W-1:0]      acc_rnd;
    logic signed [LAP_W-1:0] lap_next;
    logic [DEN_W-1:0]      den;
    logic [DEN_W-1:0]      damp_c;
    logic [NUM_W-1:0]      num_mag;
    logic [DEN_W:0]        rem_sh;
    logic                  qbit;

    assign out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            awfd_pkg::B_IDLE: begin
                if (i_q_valid) begin
                    n_state = i_q_item.stencil ? awfd_pkg::B_READ : awfd_pkg::B_FIN;
                end
            end
            awfd_pkg::B_READ: begin
                if (r_idx == awfd_pkg::TERM_LEAD) n_state = awfd_pkg::B_DRAIN;
            end
            awfd_pkg::B_DRAIN: begin
                if (!r_rd_v && !r_prod_v) n_state = awfd_pkg::B_LAP;
            end
            awfd_pkg::B_LAP:  n_state = awfd_pkg::B_DIFF;
            awfd_pkg::B_DIFF: n_state = awfd_pkg::B_MUL;
            awfd_pkg::B_MUL:  n_state = awfd_pkg::B_NUM;
            awfd_pkg::B_NUM:  n_state = awfd_pkg::B_ABS;
            awfd_pkg::B_ABS:  n_state = awfd_pkg::B_DIV;
            awfd_pkg::B_DIV: begin
                if (r_cnt == DCNT_W'(DVD_W - 1)) n_state = awfd_pkg::B_SAT;
            end
            awfd_pkg::B_SAT:  n_state = awfd_pkg::B_FIN;
            awfd_pkg::B_FIN: begin
                if (!r_job.emit || out_free) n_state = awfd_pkg::B_IDLE;
            end
            default:          n_state = awfd_pkg::B_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop    = 1'b0;
        rd_issue = 1'b0;
        mem_we   = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            awfd_pkg::B_IDLE: o_pop    = i_q_valid;
            awfd_pkg::B_READ: rd_issue = 1'b1;
            awfd_pkg::B_FIN: begin
                mem_we   = !r_job.emit || out_free;
                out_load = r_job.emit && out_free;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // stencil tap addressing
    always_comb begin
        cs     = r_job.slot + SLOT_W'(awfd_pkg::HALF);
        rd_col = cs;
        rd_row = r_job.row;
        k      = '0;
        case (r_idx) inside
            [5'd1:5'd4]: begin
                k      = r_idx[2:0];
                rd_row = r_job.row - ROW_W'(k);
            end
            [5'd5:5'd8]: begin
                k      = 3'(r_idx - 5'd4);
                rd_row = r_job.row + ROW_W'(k);
            end
            [5'd9:5'd11]: begin
                k      = 3'(r_idx - 5'd8);
                rd_col = cs + SLOT_W'(k);
            end
            [5'd12:5'd14]: begin
                k      = 3'(r_idx - 5'd11);
                rd_col = cs - SLOT_W'(k);
            end
            5'd15: rd_col = r_job.slot;
            default: rd_col = cs;
        endcase
    end

    always_comb begin
        term     = (r_rd_tag == awfd_pkg::TERM_LEAD) ? r_job.lead : $signed(r_rd_q);
        acc_mag  = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        acc_rnd  = (acc_mag + LAP_RND) >> awfd_pkg::LAP_SHIFT;
        lap_next = r_acc[ACC_W-1] ? -$signed(acc_rnd[LAP_W-1:0])
                                  : $signed(acc_rnd[LAP_W-1:0]);
        den      = DEN_W'(1 << G_W) + DEN_W'(r_job.damp);
        damp_c   = DEN_W'(1 << G_W) - DEN_W'(r_job.damp);
        num_mag  = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
        rem_sh   = {r_rem, r_dvd[DVD_W-1]};
        qbit     = rem_sh >= {1'b0, r_den};
    end

    // column memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[{r_job.slot, r_job.row}] <= r_job.lead;
        end
        r_rd_q <= r_mem[{rd_col, rd_row}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= awfd_pkg::B_IDLE;
            r_rd_v      <= 1'b0;
            r_prod_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_v   <= rd_issue;
            r_prod_v <= r_rd_v;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_tag <= r_idx;
        r_prod   <= awfd_pkg::term_coef(r_rd_tag) * term;
        if (r_rd_v && r_rd_tag == '0) begin
            r_pc <= $signed(r_rd_q);
        end
        if (r_prod_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (o_pop) begin
            r_job     <= i_q_item;
            r_idx     <= '0;
            r_acc     <= '0;
            r_res     <= i_q_item.prev;
            r_applied <= 1'b0;
        end
        if (rd_issue) begin
            r_idx <= r_idx + TERM_W'(1);
        end
        if (out_load) begin
            r_out.new_pressure    <= r_res;
            r_out.stencil_applied <= r_applied;
        end
        unique case (r_state)
            awfd_pkg::B_LAP:  r_lap <= lap_next;
            awfd_pkg::B_DIFF: begin
                r_diff <= DIFF_W'(r_lap) - DIFF_W'(r_job.src);
                r_m2   <= $signed({1'b0, damp_c}) * r_job.prev;
            end
            awfd_pkg::B_MUL:  r_m1 <= $signed({1'b0, r_job.vel}) * r_diff;
            awfd_pkg::B_NUM: begin
                r_num <= (NUM_W'(r_pc) <<< (G_W + 1)) - NUM_W'(r_m2) + NUM_W'(r_m1);
            end
            awfd_pkg::B_ABS: begin
                r_den <= den;
                r_neg <= r_num[NUM_W-1];
                r_dvd <= DVD_W'(num_mag) + DVD_W'(den >> 1);
                r_rem <= '0;
                r_cnt <= '0;
            end
            awfd_pkg::B_DIV: begin
                // restoring division, quotient shifts in behind the dividend
                r_rem <= qbit ? DEN_W'(rem_sh - {1'b0, r_den}) : DEN_W'(rem_sh);
                r_dvd <= {r_dvd[DVD_W-2:0], qbit};
                r_cnt <= r_cnt + DCNT_W'(1);
            end
            awfd_pkg::B_SAT: begin
                r_applied <= 1'b1;
                if (!r_neg) begin
                    r_res <= (r_dvd > P_MAX) ? $signed(P_MAX[P_W-1:0])
                                             : $signed(r_dvd[P_W-1:0]);
                end else begin
                    r_res <= (r_dvd > P_MIN_MAG) ? $signed(P_MIN_MAG[P_W-1:0])
                                                 : -$signed(r_dvd[P_W-1:0]);
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_rd_in_gather: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_v |-> (r_state == awfd_pkg::B_READ || r_state == awfd_pkg::B_DRAIN))
        else $error("memory read outside stencil gather");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == awfd_pkg::B_READ |-> r_idx <= awfd_pkg::TERM_LEAD)
        else $error("tap index out of range");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result overwrote a held item");

    a_write_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> r_state == awfd_pkg::B_IDLE)
        else $error("lead stored without finishing item");

endmodule

[hdl/acoustic_wave_fd_step.sv]
// ----------------------------------------------------------------------------
// acoustic_wave_fd_step
// One time step of a 2D acoustic wave solver with an eighth-order cross
// Laplacian and damped border, fed column by column.
//
//   channel   direction  handshake                 payload
//   cfg       in         i_cfg_wr_en               i_cfg_wr_data (column height)
//   in        in         i_in_valid / o_in_stall   i_in_item
//   out       out        o_out_valid / i_out_stall o_out_item
//
// Border and pass-through items skip from idle to the final state in the back
// end; stencil items read 17 taps through the single read port of the column
// memory, drain the multiply-accumulate pipeline, pass the arithmetic steps
// and run a one-bit-per-cycle divider. The front takes an item per cycle until
// the 4-entry queue fills. Reset is synchronous and clears counters, queue and
// output valid; the column memory is not cleared. A stalled result holds the
// back end in its final state while the front keeps filling the queue.
// ----------------------------------------------------------------------------
module acoustic_wave_fd_step (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [awfd_pkg::H_W-1:0]    i_cfg_wr_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  awfd_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output awfd_pkg::t_out_item         o_out_item
);

    awfd_pkg::t_job push_job;
    awfd_pkg::t_job q_job;
    logic           push;
    logic           full;
    logic           pop;
    logic           q_valid;

    awfd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_item     (i_in_item),
        .i_full        (full),
        .o_push        (push),
        .o_job         (push_job)
    );

    awfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_job)
    );

    awfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

[dv/acoustic_wave_fd_step_tb.sv]
// ----------------------------------------------------------------------------
// acoustic_wave_fd_step_tb
// Streams grid points through the wave step in phases of different column
// heights, with random idle and stall patterns on both channels. A
// scoreboard keeps its own column store and predicts every result in order.
// ----------------------------------------------------------------------------
module acoustic_wave_fd_step_tb;
    import awfd_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int SETTLE       = 500;
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_POINTS = 160;

    // scoreboard: predicts the next pressure for each accepted item that yields a result
    class wave_step_board;
        logic signed [P_W-1:0] grid[NCOLS][MAX_H];
        int unsigned row_idx;
        int unsigned cols_seen;
        int unsigned lead_col;
        int unsigned height;
        t_out_item   pending_pressures[$];
        int          errors;
        int          points_in;
        int          updated_seen;
        int          passed_seen;

        function new();
            foreach (grid[s, r]) grid[s][r] = '0;
            row_idx = 0; cols_seen = 0; lead_col = 0; height = MAX_H;
            errors = 0; points_in = 0; updated_seen = 0; passed_seen = 0;
        endfunction

        function int unsigned eff_height();
            if (height < MIN_H) return MIN_H;
            if (height > MAX_H) return MAX_H;
            return height;
        endfunction

        function longint round_div(longint num, longint den);
            if (num >= 0) return (num + den / 2) / den;
            return -((-num + den / 2) / den);
        endfunction

        function longint cell_at(int unsigned s, int unsigned r);
            return longint'($signed(grid[s % NCOLS][r]));
        endfunction

        function void accept_point(t_in_item it);
            longint lead, prev, vel, damp, src, far_left, pc, acc, lap, num, res;
            longint maxv, minv, sum;
            int unsigned h, r, s, cs;
            t_out_item exp_item;
            lead = longint'(it.lead_pressure);
            prev = longint'(it.center_prev_pressure);
            vel  = longint'({1'b0, it.velocity_coef});
            damp = longint'({1'b0, it.damping});
            src  = longint'(it.source_term);
            points_in++;
            if (it.frame_start) begin
                row_idx = 0; cols_seen = 0; lead_col = 0;
            end
            h = eff_height();
            if (row_idx >= h) row_idx = h - 1;
            r = row_idx;
            s = lead_col % NCOLS;
            far_left = cell_at(s, r);
            grid[s][r] = it.lead_pressure;
            if (cols_seen >= HALF) begin
                cs = (s + NCOLS - HALF) % NCOLS;
                res = prev;
                exp_item.stencil_applied = 1'b0;
                if (cols_seen >= NCOLS && r >= HALF && r + HALF + 2 <= h) begin
                    pc  = cell_at(cs, r);
                    acc = longint'(C0) * pc;
                    for (int k = 1; k <= HALF; k++) begin
                        sum = cell_at(cs, r - k) + cell_at(cs, r + k);
                        sum += (k == HALF) ? lead : cell_at(cs + k, r);
                        sum += (k == HALF) ? far_left : cell_at(cs + NCOLS - k, r);
                        case (k)
                            1: acc += longint'(C1) * sum;
                            2: acc += longint'(C2) * sum;
                            3: acc += longint'(C3) * sum;
                            default: acc += longint'(C4) * sum;
                        endcase
                    end
                    lap = round_div(acc, 64'sd1 << LAP_SHIFT);
                    num = pc * 2 * 65536 - (65536 - damp) * prev + vel * (lap - src);
                    res = round_div(num, 65536 + damp);
                    maxv = (64'sd1 <<< (P_W - 1)) - 1;
                    minv = -maxv - 1;
                    if (res > maxv) res = maxv;
                    if (res < minv) res = minv;
                    exp_item.stencil_applied = 1'b1;
                end
                exp_item.new_pressure = res[P_W-1:0];
                pending_pressures.push_back(exp_item);
            end
            if (r + 1 >= h) begin
                row_idx = 0;
                if (cols_seen < NCOLS) cols_seen++;
                lead_col = (s + 1) % NCOLS;
            end else begin
                row_idx = r + 1;
            end
        endfunction

        function void check_point(t_out_item got);
            t_out_item want;
            if (pending_pressures.size() == 0) begin
                $error("result with nothing expected: new_pressure %0d",
                       $signed(got.new_pressure));
                errors++;
                return;
            end
            want = pending_pressures.pop_front();
            if (got.new_pressure !== want.new_pressure) begin
                $error("new_pressure expected %0d actual %0d",
                       $signed(want.new_pressure), $signed(got.new_pressure));
                errors++;
            end
            if (got.stencil_applied !== want.stencil_applied) begin
                $error("stencil_applied expected %0b actual %0b",
                       want.stencil_applied, got.stencil_applied);
                errors++;
            end
            if (want.stencil_applied) updated_seen++;
            else passed_seen++;
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_wr_en = 1'b0;
    logic [H_W-1:0]   i_cfg_wr_data = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    t_in_item         i_in_item = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_item        o_out_item;

    int unsigned      send_idle_pct = 0;
    int unsigned      recv_stall_pct = 0;
    int unsigned      cycle_count = 0;

    wave_step_board   board = new();

    acoustic_wave_fd_step i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_item     (i_in_item),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_item    (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: check on accept, then pick next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_point(o_out_item);
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic logic [P_W-1:0] pick_pressure();
        case ($urandom_range(9))
            0: return {1'b0, {(P_W-1){1'b1}}};
            1: return {1'b1, {(P_W-1){1'b0}}};
            2: return '0;
            3: return '1;
            4, 5: return P_W'($signed($urandom_range(1 << 24)) - (1 << 23));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [G_W-1:0] pick_coef();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            default: return G_W'($urandom);
        endcase
    endfunction

    task automatic send_point(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        board.accept_point(it);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (board.pending_pressures.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_height(logic [H_W-1:0] h);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= h;
        @(posedge i_clk);
        board.height = h;
        i_cfg_wr_en   <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int unsigned phase_h[NUM_PHASES] =
            '{10, 0, 13, 2047, 17, 12, 10, 31, 1024, 20, 11, 24};
        t_in_item    it;
        int unsigned old_eff;
        int unsigned npoints;
        logic        keep_frame;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes at the reset height: all within the first column, so no results
        for (int n = 0; n < 20; n++) begin
            it.lead_pressure        = (n % 4 == 0) ? {1'b0, {(P_W-1){1'b1}}} :
                                      (n % 4 == 1) ? {1'b1, {(P_W-1){1'b0}}} :
                                      (n % 4 == 2) ? '0 : '1;
            it.center_prev_pressure = (n % 3 == 0) ? {1'b1, {(P_W-1){1'b0}}} : ~it.lead_pressure;
            it.velocity_coef        = (n % 2) ? '1 : '0;
            it.damping              = (n % 5 < 2) ? '1 : '0;
            it.source_term          = it.lead_pressure;
            it.frame_start          = (n == 0) || (n == 11);
            send_point(it);
        end
        drain_results();

        for (int p = 0; p < NUM_PHASES; p++) begin
            old_eff = board.eff_height();
            write_height(phase_h[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            // a column no taller keeps the running frame: every read row is written
            keep_frame = (board.cols_seen == NCOLS) && (board.eff_height() <= old_eff);
            npoints = (board.eff_height() == MAX_H) ? 120 : PHASE_POINTS;
            for (int n = 0; n < npoints; n++) begin
                it.lead_pressure        = pick_pressure();
                it.center_prev_pressure = pick_pressure();
                it.velocity_coef        = pick_coef();
                it.damping              = pick_coef();
                it.source_term          = pick_pressure();
                it.frame_start          = (n == 0 && !keep_frame) || ($urandom_range(99) == 0);
                if (p == 6 && n == 80) drain_results();
                send_point(it);
            end
            drain_results();
        end

        if (board.pending_pressures.size() != 0) begin
            $error("%0d results never arrived", board.pending_pressures.size());
            board.errors++;
        end
        $display("%0d points sent over %0d column heights", board.points_in, NUM_PHASES);
        $display("%0d stencil updates and %0d border pass-throughs checked",
                 board.updated_seen, board.passed_seen);
        if (board.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
